FILE: rtl/core/kps_pkg.sv
package kps_pkg;

  // Field widths of the item and result channels
  localparam int IDX_W    = 6;
  localparam int DUR_W    = 32;
  localparam int FRAME_W  = 8;
  localparam int DELTA_W  = 16;
  localparam int WEIGHT_W = 17;

  // Configuration register widths
  localparam int COUNT_W = 7;
  localparam int SPEED_W = 16;

  // Fraction bits of the blend weight, one quotient bit per divider step
  localparam int FRAC_W = 16;

  // Blend weight of exactly 1.0
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  // Item action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // APB port geometry
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Configuration register map (word index)
  typedef enum logic [2:0] {
    REG_KEY_COUNT   = 3'd0,
    REG_LOOP_EN     = 3'd1,
    REG_BOUNCE_EN   = 3'd2,
    REG_START_REV   = 3'd3,
    REG_START_KEY   = 3'd4,
    REG_SPEED       = 3'd5
  } kps_reg_e;

endpackage

FILE: rtl/core/kps_if.sv
// Input item channel
interface kps_item_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [kps_pkg::IDX_W-1:0]   key_index;
  logic [kps_pkg::DUR_W-1:0]   key_duration;
  logic [kps_pkg::FRAME_W-1:0] key_frame;
  logic [kps_pkg::DELTA_W-1:0] delta_time;

  modport source (
    output valid, action, key_index, key_duration, key_frame, delta_time,
    input  ready
  );
  modport sink (
    input  valid, action, key_index, key_duration, key_frame, delta_time,
    output ready
  );
endinterface

// Result channel
interface kps_result_if;
  logic                         valid;
  logic                         ready;
  logic [kps_pkg::FRAME_W-1:0]  from_frame;
  logic [kps_pkg::FRAME_W-1:0]  to_frame;
  logic [kps_pkg::WEIGHT_W-1:0] blend_weight;
  logic                         segment_changed;
  logic                         finished;

  modport source (
    output valid, from_frame, to_frame, blend_weight, segment_changed, finished,
    input  ready
  );
  modport sink (
    input  valid, from_frame, to_frame, blend_weight, segment_changed, finished,
    output ready
  );
endinterface

FILE: rtl/core/keyframe_playback_sequencer.sv
// Keyframe playback sequencer.
// Tick: add, advance, table read, the 16-step divider, the frame reads, then emit;
// the divider is skipped when the weight saturates at 1.0, and a non-loop stop goes from
// add straight to the frame reads; one item in work at a time. Table write: straight to emit.
// A held result stalls the next item in emit, and so the input, until the output register frees up.
// Reset: playback state and config registers return to defaults; the key table is not cleared.
module keyframe_playback_sequencer #(
  parameter int MAX_KEYS   = 64,
  parameter int FRAME_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kps_item_if.sink                    item_i,
  kps_result_if.source                result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kps_pkg::APB_AW-1:0]  paddr,
  input  logic [kps_pkg::APB_DW-1:0]  pwdata,
  output logic [kps_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  // Derived widths
  localparam int KW   = $clog2(MAX_KEYS);
  localparam int CW   = ($clog2(MAX_KEYS + 1) > 7) ? $clog2(MAX_KEYS + 1) : 7;
  localparam int FW   = (FRAME_BITS < 8) ? FRAME_BITS : 8;
  localparam int DW   = kps_pkg::DUR_W;
  localparam int MW   = DW + FW;
  localparam int PW   = 2 * kps_pkg::SPEED_W;
  localparam int FRW  = kps_pkg::FRAME_W;
  localparam int WW   = kps_pkg::WEIGHT_W;
  localparam int QW   = kps_pkg::FRAC_W;
  localparam int SW   = $clog2(QW);
  localparam int DATW = kps_pkg::APB_DW;
  localparam logic [SW-1:0] STEP_LAST = SW'(QW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_ADV, S_RDD, S_DIVST, S_DIV, S_RDF_A, S_RDF_B, S_RDF_C, S_EMIT
  } state_e;

  // Configuration registers
  logic [kps_pkg::COUNT_W-1:0] key_count_q;
  logic                        loop_q;
  logic                        bounce_q;
  logic                        start_rev_q;
  logic [kps_pkg::IDX_W-1:0]   start_key_q;
  logic [kps_pkg::SPEED_W-1:0] speed_q;

  // Control and playback state
  state_e            state_q;
  logic              primed_q;
  logic [KW-1:0]     fk_q;
  logic [KW-1:0]     sk_q;
  logic              bw_q;
  logic [DW-1:0]     el_q;
  logic [PW-1:0]     prod_q;

  // Divider
  logic [DW-1:0]     rem_q;
  logic [DW-1:0]     div_q;
  logic [QW-1:0]     quo_q;
  logic [SW-1:0]     step_q;

  // Result staging and output register
  logic [FW-1:0]     res_from_q;
  logic [FW-1:0]     res_to_q;
  logic [WW-1:0]     res_w_q;
  logic              res_chg_q;
  logic              res_fin_q;
  logic              out_valid_q;
  logic [FRW-1:0]    out_from_q;
  logic [FRW-1:0]    out_to_q;
  logic [WW-1:0]     out_w_q;
  logic              out_chg_q;
  logic              out_fin_q;

  // Key table: {duration, frame} per entry
  logic [MW-1:0]     mem [MAX_KEYS];
  logic [MW-1:0]     rd_q;
  logic [KW-1:0]     raddr;
  logic [KW-1:0]     waddr;
  logic              mem_we;
  logic [DW-1:0]     rd_dur;
  logic [FW-1:0]     rd_frame;

  logic              item_xfer;
  logic              cfg_wr;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     kc_ext;
  logic [CW-1:0]     stk_ext;
  logic [CW-1:0]     start_sel;
  logic [CW-1:0]     wr_idx_ext;
  logic [CW-1:0]     sk_plus;
  logic              at_end;
  logic              stop;
  logic [DW:0]       sum;
  logic [DW-1:0]     el_add;
  logic [KW-1:0]     fk_adv;
  logic [KW-1:0]     sk_adv;
  logic              bw_adv;
  logic [DW:0]       rem_sh;
  logic [DW:0]       rem_sub;
  logic              div_ge;
  logic [DW-1:0]     rem_nx;
  logic [QW-1:0]     quo_nx;

  // Handshakes
  assign item_xfer  = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= kps_pkg::COUNT_W'(2);
      loop_q      <= 1'b0;
      bounce_q    <= 1'b0;
      start_rev_q <= 1'b0;
      start_key_q <= '0;
      speed_q     <= kps_pkg::SPEED_W'(256);
    end else if (cfg_wr) begin
      case (kps_pkg::kps_reg_e'(paddr[4:2]))
        kps_pkg::REG_KEY_COUNT: key_count_q <= pwdata[kps_pkg::COUNT_W-1:0];
        kps_pkg::REG_LOOP_EN:   loop_q      <= pwdata[0];
        kps_pkg::REG_BOUNCE_EN: bounce_q    <= pwdata[0];
        kps_pkg::REG_START_REV: start_rev_q <= pwdata[0];
        kps_pkg::REG_START_KEY: start_key_q <= pwdata[kps_pkg::IDX_W-1:0];
        kps_pkg::REG_SPEED:     speed_q     <= pwdata[kps_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (kps_pkg::kps_reg_e'(paddr[4:2]))
      kps_pkg::REG_KEY_COUNT: prdata = DATW'(key_count_q);
      kps_pkg::REG_LOOP_EN:   prdata = DATW'(loop_q);
      kps_pkg::REG_BOUNCE_EN: prdata = DATW'(bounce_q);
      kps_pkg::REG_START_REV: prdata = DATW'(start_rev_q);
      kps_pkg::REG_START_KEY: prdata = DATW'(start_key_q);
      kps_pkg::REG_SPEED:     prdata = DATW'(speed_q);
      default:                prdata = '0;
    endcase
  end

  // Effective key count, clamped to [2, MAX_KEYS], and clamped start key
  always_comb begin
    kc_ext    = CW'(key_count_q);
    if (kc_ext < CW'(2)) begin
      cnt = CW'(2);
    end else if (kc_ext > CW'(MAX_KEYS)) begin
      cnt = CW'(MAX_KEYS);
    end else begin
      cnt = kc_ext;
    end
    cnt_m1    = cnt - CW'(1);
    stk_ext   = CW'(start_key_q);
    start_sel = (stk_ext < cnt) ? stk_ext : cnt_m1;
  end

  // Timer add with saturation, end-of-playback check
  assign at_end = bw_q ? (fk_q == '0) : (CW'(sk_q) >= cnt_m1);
  assign stop   = !loop_q && at_end;
  assign sum    = {1'b0, el_q} + (DW + 1)'(prod_q[PW-1:8]);
  assign el_add = sum[DW] ? '1 : sum[DW-1:0];

  // Next key pair when the segment is passed
  always_comb begin
    fk_adv  = sk_q;
    bw_adv  = bw_q;
    sk_plus = CW'(sk_q) + CW'(1);
    if (!bw_q) begin
      if (sk_plus >= cnt) begin
        if (bounce_q) begin
          bw_adv = 1'b1;
          sk_adv = sk_q - KW'(1);
        end else begin
          sk_adv = '0;
        end
      end else begin
        sk_adv = sk_plus[KW-1:0];
      end
    end else begin
      if (sk_q == '0) begin
        if (bounce_q) begin
          bw_adv = 1'b0;
          sk_adv = KW'(1);
        end else begin
          sk_adv = cnt_m1[KW-1:0];
        end
      end else begin
        sk_adv = sk_q - KW'(1);
      end
    end
  end

  // One restoring divider step: one quotient bit
  assign rem_sh  = {rem_q, 1'b0};
  assign div_ge  = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign rem_nx  = div_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
  assign quo_nx  = {quo_q[QW-2:0], div_ge};

  // Table port: writes only from idle; reads run every cycle, but their data is used only
  // while a tick is in work, so a write never overlaps a read whose data is used
  assign wr_idx_ext = CW'(item_i.key_index);
  assign waddr      = wr_idx_ext[KW-1:0];
  assign mem_we     = item_xfer && (item_i.action == kps_pkg::ACT_WRITE)
                      && (wr_idx_ext < CW'(MAX_KEYS));

  always_comb begin
    case (state_q)
      S_ADD, S_RDD: raddr = bw_q ? fk_q : sk_q;
      S_RDF_B:      raddr = sk_q;
      default:      raddr = fk_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= {item_i.key_duration, item_i.key_frame[FW-1:0]};
    end
    rd_q <= mem[raddr];
  end

  assign rd_dur   = rd_q[MW-1:FW];
  assign rd_frame = rd_q[FW-1:0];

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      primed_q    <= 1'b0;
      fk_q        <= '0;
      sk_q        <= '0;
      bw_q        <= 1'b0;
      el_q        <= '0;
      prod_q      <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      res_from_q  <= '0;
      res_to_q    <= '0;
      res_w_q     <= '0;
      res_chg_q   <= 1'b0;
      res_fin_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_from_q  <= '0;
      out_to_q    <= '0;
      out_w_q     <= '0;
      out_chg_q   <= 1'b0;
      out_fin_q   <= 1'b0;
    end else begin
      // output register drains; the emit state refills it itself
      if (out_valid_q && result_o.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (item_xfer) begin
            if (item_i.action == kps_pkg::ACT_WRITE) begin
              res_from_q <= '0;
              res_to_q   <= '0;
              res_w_q    <= '0;
              res_chg_q  <= 1'b0;
              res_fin_q  <= 1'b0;
              state_q    <= S_EMIT;
            end else begin
              // first tick loads the start position
              if (!primed_q) begin
                primed_q <= 1'b1;
                fk_q     <= start_sel[KW-1:0];
                sk_q     <= start_sel[KW-1:0];
                bw_q     <= start_rev_q;
                el_q     <= '0;
              end
              prod_q    <= PW'(speed_q) * PW'(item_i.delta_time);
              res_chg_q <= 1'b0;
              res_fin_q <= 1'b0;
              state_q   <= S_ADD;
            end
          end
        end
        S_ADD: begin
          if (stop) begin
            el_q      <= '0;
            res_fin_q <= 1'b1;
            res_w_q   <= bw_q ? '0 : kps_pkg::WEIGHT_ONE;
            state_q   <= S_RDF_A;
          end else begin
            el_q    <= el_add;
            state_q <= S_ADV;
          end
        end
        S_ADV: begin
          // zero duration always counts as passed
          if (el_q >= rd_dur) begin
            el_q      <= el_q - rd_dur;
            fk_q      <= fk_adv;
            sk_q      <= sk_adv;
            bw_q      <= bw_adv;
            res_chg_q <= 1'b1;
          end
          state_q <= S_RDD;
        end
        S_RDD: begin
          state_q <= S_DIVST;
        end
        S_DIVST: begin
          // timer at or past the duration saturates the weight at 1.0
          if (el_q >= rd_dur) begin
            res_w_q <= kps_pkg::WEIGHT_ONE;
            state_q <= S_RDF_A;
          end else begin
            rem_q   <= el_q;
            div_q   <= rd_dur;
            quo_q   <= '0;
            step_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= rem_nx;
          quo_q  <= quo_nx;
          step_q <= step_q + SW'(1);
          if (step_q == STEP_LAST) begin
            res_w_q <= WW'(quo_nx);
            state_q <= S_RDF_A;
          end
        end
        S_RDF_A: begin
          state_q <= S_RDF_B;
        end
        S_RDF_B: begin
          res_from_q <= rd_frame;
          state_q    <= S_RDF_C;
        end
        S_RDF_C: begin
          res_to_q <= rd_frame;
          state_q  <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || result_o.ready) begin
            out_valid_q <= 1'b1;
            out_from_q  <= FRW'(res_from_q);
            out_to_q    <= FRW'(res_to_q);
            out_w_q     <= res_w_q;
            out_chg_q   <= res_chg_q;
            out_fin_q   <= res_fin_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result channel
  assign result_o.valid           = out_valid_q;
  assign result_o.from_frame      = out_from_q;
  assign result_o.to_frame        = out_to_q;
  assign result_o.blend_weight    = out_w_q;
  assign result_o.segment_changed = out_chg_q;
  assign result_o.finished        = out_fin_q;

  // Checks
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_xfer |=> !item_i.ready)
    else $error("item taken while previous item in work");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_w_q <= kps_pkg::WEIGHT_ONE))
    else $error("blend weight above 1.0");

  a_chg_fin_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_chg_q && out_fin_q))
    else $error("advance reported on a stopped tick");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

endmodule
